[hw/rtl/bwec_pkg.sv]
// ---------------------------------------------------------------------------
// bwec_pkg
// Shared types and constants of the binned window event counter.
// ---------------------------------------------------------------------------
package bwec_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned TOT_W   = 40;
	localparam int unsigned FW_W    = 16;
	localparam int unsigned WS_W    = 34;
	localparam int unsigned BLEN_W  = 16;
	localparam int unsigned SPAN_W  = 17;
	localparam int unsigned DIV_W   = 34;
	localparam int unsigned DVS_W   = 17;
	localparam int unsigned DCNT_W  = 6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CDIV,
		ST_CHK,
		ST_CLS,
		ST_RDIV,
		ST_IDIV,
		ST_IWR,
		ST_RADV,
		ST_RRD,
		ST_RFIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

endpackage

[hw/rtl/bwec_div.sv]
// ---------------------------------------------------------------------------
// bwec_div
// Restoring serial divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bwec_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bwec_pkg::div_req_t req,
	output bwec_pkg::div_rsp_t rsp
);

	logic [bwec_pkg::DIV_W-1:0]  quo_q;
	logic [bwec_pkg::DVS_W-1:0]  rem_q;
	logic [bwec_pkg::DVS_W-1:0]  dvs_q;
	logic [bwec_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [bwec_pkg::DVS_W:0]    trial;

	assign trial = {rem_q, quo_q[bwec_pkg::DIV_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= bwec_pkg::DCNT_W'(bwec_pkg::DIV_W);
		end else begin
			done_q <= busy_q && (cnt_q == bwec_pkg::DCNT_W'(1));
			if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == bwec_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= bwec_pkg::DVS_W'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[bwec_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[bwec_pkg::DVS_W-1:0];
				quo_q <= {quo_q[bwec_pkg::DIV_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

[hw/rtl/bwec_bin_mem.sv]
// ---------------------------------------------------------------------------
// bwec_bin_mem
// Bin count memory, one write and one registered read port, valid per entry.
// ---------------------------------------------------------------------------
module bwec_bin_mem #(
	parameter int unsigned NUM_BINS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clr,
	input  logic                          we,
	input  logic [$clog2(NUM_BINS)-1:0]   waddr,
	input  logic [bwec_pkg::CNT_W-1:0]    wdata,
	input  logic                          re,
	input  logic [$clog2(NUM_BINS)-1:0]   raddr,
	output logic [bwec_pkg::CNT_W-1:0]    rdata
);

	logic [bwec_pkg::CNT_W-1:0] mem [NUM_BINS];
	logic [NUM_BINS-1:0]        vld_q;
	logic [bwec_pkg::CNT_W-1:0] rd_q;
	logic                       rv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv_q  <= 1'b0;
		end else begin
			if (re) begin
				rv_q <= vld_q[raddr];
			end
			if (clr) begin
				vld_q <= we ? (NUM_BINS'(1) << waddr) : '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rv_q ? rd_q : '0;

endmodule

[hw/rtl/binned_window_event_counter.sv]
// ---------------------------------------------------------------------------
// binned_window_event_counter
// Event total over a sliding window kept as a ring of bins in a memory.
// ---------------------------------------------------------------------------
// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   tdata: event_time[31:0], event_count[47:32]
// m_       out  m_tvalid/m_tready   tdata: window_total[39:0]
// cfg_     in   cfg_valid/cfg_ready cfg_data: fail_window[15:0]
//
// An early event is not counted; an in-window one adds to its bin after a
// serial divide (34 steps), a far one restarts the window after one, and a
// late one retires a bin per RADV/RRD pass. A register write sets the bin
// length by a reciprocal multiply; it and reset clear the history at once
// (valid bit per bin). A result waits in the output register and the next
// event is taken meanwhile; a finished event holds while the register is full.
// ---------------------------------------------------------------------------
module binned_window_event_counter #(
	parameter int unsigned NUM_BINS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // event_time[31:0], event_count[47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // window_total[39:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int unsigned IW     = $clog2(NUM_BINS);
	localparam int unsigned RCP_W  = bwec_pkg::SPAN_W + 2;
	localparam int unsigned PROD_W = bwec_pkg::SPAN_W + RCP_W;
	localparam int unsigned RCP_SH = bwec_pkg::SPAN_W + IW;
	localparam int unsigned RCP    = ((1 << RCP_SH) + NUM_BINS - 1) / NUM_BINS;

	bwec_pkg::state_t state_q, state_d;
	bwec_pkg::div_req_t div_req;
	bwec_pkg::div_rsp_t div_rsp;

	logic [bwec_pkg::BLEN_W-1:0]  blen_q;
	logic [bwec_pkg::SPAN_W-1:0]  span_q;
	logic [bwec_pkg::SPAN_W-1:0]  dvd_q;
	logic signed [bwec_pkg::WS_W-1:0] ws_q;
	logic [bwec_pkg::TIME_W-1:0]  last_q;
	logic [IW-1:0]                cur_q;
	logic [IW-1:0]                idx_q;
	logic [bwec_pkg::TOT_W-1:0]   tot_q;
	logic [bwec_pkg::TIME_W-1:0]  t_q;
	logic [bwec_pkg::CNT_W-1:0]   n_q;
	logic                         m_valid_q;
	logic [bwec_pkg::TOT_W-1:0]   m_data_q;

	logic signed [35:0] t_x, ws_x, span_x, blen_x, rem_x, wend_x;
	logic [IW-1:0]      cur_next;
	logic [IW:0]        idx_sum, idx_fix;
	logic               early, far, in_span, more;
	logic               cfg_acc, s_acc, m_load;
	logic [PROD_W-1:0]  blen_prod, blen_quo;

	logic               mem_clr, mem_we, mem_re;
	logic [IW-1:0]      mem_waddr, mem_raddr;
	logic [bwec_pkg::CNT_W-1:0] mem_wdata, mem_rdata;

	assign t_x    = $signed({4'b0, t_q});
	assign ws_x   = $signed({{2{ws_q[bwec_pkg::WS_W-1]}}, ws_q});
	assign span_x = $signed({19'b0, span_q});
	assign blen_x = $signed({20'b0, blen_q});
	assign rem_x  = $signed({19'b0, div_rsp.rem});
	assign wend_x = ws_x + span_x;

	assign early   = t_x < ws_x;
	assign far     = {1'b0, t_q} > ({1'b0, last_q} + {16'b0, span_q});
	assign in_span = t_x < wend_x;
	assign more    = wend_x < t_x;

	assign blen_prod = {{RCP_W{1'b0}}, dvd_q} * {{bwec_pkg::SPAN_W{1'b0}}, RCP_W'(RCP)};
	assign blen_quo  = blen_prod >> RCP_SH;

	assign cur_next = (cur_q == IW'(NUM_BINS - 1)) ? '0 : cur_q + 1'b1;
	assign idx_sum  = {1'b0, div_rsp.quot[IW-1:0]} + (IW+1)'(1) + {1'b0, cur_q};
	assign idx_fix  = (idx_sum >= (IW+1)'(NUM_BINS)) ? idx_sum - (IW+1)'(NUM_BINS)
	                                                 : idx_sum;

	assign s_tready  = (state_q == bwec_pkg::ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == bwec_pkg::ST_IDLE);
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign s_acc     = s_tvalid && s_tready;
	assign m_load    = (state_q == bwec_pkg::ST_DONE) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bwec_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = bwec_pkg::DIV_W'({t_q});
		div_req.divisor  = {1'b0, blen_q};
		mem_clr          = 1'b0;
		mem_we           = 1'b0;
		mem_waddr        = cur_q;
		mem_wdata        = n_q;
		mem_re           = 1'b0;
		mem_raddr        = cur_next;
		unique case (state_q)
			bwec_pkg::ST_IDLE: begin
				if (cfg_acc) begin
					mem_clr = 1'b1;
					state_d = bwec_pkg::ST_CDIV;
				end else if (s_acc) begin
					state_d = bwec_pkg::ST_CHK;
				end
			end
			bwec_pkg::ST_CDIV: begin
				state_d = bwec_pkg::ST_IDLE;
			end
			bwec_pkg::ST_CHK: begin
				if (early) begin
					state_d = bwec_pkg::ST_DONE;
				end else if (far) begin
					div_req.start = 1'b1;
					state_d       = bwec_pkg::ST_RDIV;
				end else begin
					state_d = bwec_pkg::ST_CLS;
				end
			end
			bwec_pkg::ST_CLS: begin
				if (in_span) begin
					div_req.start    = 1'b1;
					div_req.dividend = bwec_pkg::DIV_W'(t_x - ws_x);
					state_d          = bwec_pkg::ST_IDIV;
				end else begin
					state_d = bwec_pkg::ST_RADV;
				end
			end
			bwec_pkg::ST_RDIV: begin
				if (div_rsp.done) begin
					mem_clr   = 1'b1;
					mem_we    = 1'b1;
					mem_waddr = '0;
					state_d   = bwec_pkg::ST_DONE;
				end
			end
			bwec_pkg::ST_IDIV: begin
				if (div_rsp.done) begin
					mem_re    = 1'b1;
					mem_raddr = idx_fix[IW-1:0];
					state_d   = bwec_pkg::ST_IWR;
				end
			end
			bwec_pkg::ST_IWR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = mem_rdata + n_q;
				state_d   = bwec_pkg::ST_DONE;
			end
			bwec_pkg::ST_RADV: begin
				mem_re  = 1'b1;
				state_d = bwec_pkg::ST_RRD;
			end
			bwec_pkg::ST_RRD: begin
				if (more) begin
					mem_we    = 1'b1;
					mem_wdata = '0;
					state_d   = bwec_pkg::ST_RADV;
				end else begin
					state_d = bwec_pkg::ST_RFIN;
				end
			end
			bwec_pkg::ST_RFIN: begin
				mem_we  = 1'b1;
				state_d = bwec_pkg::ST_DONE;
			end
			bwec_pkg::ST_DONE: begin
				if (m_load) begin
					state_d = bwec_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bwec_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blen_q    <= bwec_pkg::BLEN_W'(1);
			span_q    <= bwec_pkg::SPAN_W'(NUM_BINS);
			ws_q      <= '0;
			last_q    <= '0;
			cur_q     <= '0;
			tot_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				bwec_pkg::ST_IDLE: begin
					if (cfg_acc) begin
						ws_q   <= '0;
						last_q <= '0;
						cur_q  <= '0;
						tot_q  <= '0;
					end
				end
				bwec_pkg::ST_CDIV: begin
					blen_q <= blen_quo[bwec_pkg::BLEN_W-1:0];
					span_q <= bwec_pkg::SPAN_W'(blen_quo[bwec_pkg::BLEN_W-1:0] *
					          bwec_pkg::SPAN_W'(NUM_BINS));
				end
				bwec_pkg::ST_RDIV: begin
					if (div_rsp.done) begin
						ws_q   <= bwec_pkg::WS_W'(t_x + blen_x - rem_x - span_x);
						last_q <= t_q;
						cur_q  <= '0;
						tot_q  <= bwec_pkg::TOT_W'(n_q);
					end
				end
				bwec_pkg::ST_IWR, bwec_pkg::ST_RFIN: begin
					tot_q <= tot_q + bwec_pkg::TOT_W'(n_q);
					if (last_q < t_q) begin
						last_q <= t_q;
					end
				end
				bwec_pkg::ST_RADV: begin
					ws_q  <= ws_q + $signed({18'b0, blen_q});
					cur_q <= cur_next;
				end
				bwec_pkg::ST_RRD: begin
					tot_q <= tot_q - bwec_pkg::TOT_W'(mem_rdata);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_acc) begin
			dvd_q <= {1'b0, cfg_data} + bwec_pkg::SPAN_W'(NUM_BINS);
		end
		if (s_acc) begin
			t_q <= s_tdata[31:0];
			n_q <= s_tdata[47:32];
		end
		if ((state_q == bwec_pkg::ST_IDIV) && div_rsp.done) begin
			idx_q <= idx_fix[IW-1:0];
		end
		if (m_load) begin
			m_data_q <= tot_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	bwec_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	bwec_bin_mem #(
		.NUM_BINS (NUM_BINS)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (mem_clr),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

endmodule

[hw/rtl/bwec_chk.sv]
// ---------------------------------------------------------------------------
// bwec_chk
// Port-level checks of the binned window event counter.
// ---------------------------------------------------------------------------
module bwec_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transaction dropped or changed while stalled");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !cfg_ready)
		else $error("input taken again straight after a transaction");

	a_busy_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !s_tready && !cfg_ready)
		else $error("ready straight after a register write");

	a_ready_pair: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> cfg_ready)
		else $error("input ready while the register port is busy");

endmodule

bind binned_window_event_counter bwec_chk u_bwec_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
